// ----- design/pidaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types, constants and helpers for the incremental PID controller
// with back-calculation anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int FRAC_W     = 24;
   localparam int RND_W      = PROD_W - FRAC_W;
   localparam int ACC_W      = 44;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd8388608);

   localparam logic signed [DATA_W-1:0] WINDUP_RST   = 32'sd2399;
   localparam logic signed [DATA_W-1:0] LIMIT_RST    = 32'sd8519680;
   localparam logic signed [DATA_W-1:0] OUT_HIGH_RST = 32'sd65536;
   localparam logic signed [DATA_W-1:0] DUTY_RST     = 32'sd6554;

   typedef enum logic [2:0] {
      REG_A0,
      REG_A1,
      REG_A2,
      REG_WG,
      REG_LIMIT,
      REG_OUT_LOW,
      REG_OUT_HIGH
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_A0,
      MUL_A1,
      MUL_A2,
      MUL_WG
   } mul_sel_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] coef_a0;
      logic signed [DATA_W-1:0] coef_a1;
      logic signed [DATA_W-1:0] coef_a2;
      logic signed [DATA_W-1:0] windup_gain;
      logic signed [DATA_W-1:0] measurement_limit;
      logic signed [DATA_W-1:0] output_low;
      logic signed [DATA_W-1:0] output_high;
   } pidaw_cfg_type;

   typedef struct packed {
      logic        capture;
      logic        check;
      mul_sel_type mul_sel;
      logic        acc_add;
      logic        clamp;
      logic        finish;
      logic        load_out;
   } pidaw_cmd_type;

   typedef struct packed {
      logic clear;
      logic held;
   } pidaw_sts_type;

   // Saturate a wide signed value to the data width.
   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-DATA_W:0] top;
      top = x[ACC_W-1:DATA_W-1];
      if ((&top) || !(|top)) begin
         return x[DATA_W-1:0];
      end else if (x[ACC_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

// ----- design/pid_antiwindup_controller_core.sv -----
// ----------------------------------------------------------------------------
// pid_antiwindup_controller_core
// Incremental PID controller with back-calculation anti-windup, fixed point.
// ----------------------------------------------------------------------------
// Input channel (req_*): one transfer carries a command, a reference and a
// measurement. The block works on one item at a time and holds req_stall
// high from acceptance until its result sits in the output register.
// Result channel (rsp_*): one transfer per input item, carrying the duty and
// the held flag. The result waits in an output register while rsp_stall is
// high; a new item is accepted meanwhile and finishes its work, then waits
// for that register to drain.
// Sequence: a control step runs from acceptance through check, four passes
// through the single shared 32x32 multiplier, clamp and update before
// rsp_valid; a clear or held item goes from check straight to the wait for
// the output register. No new item is taken until the last one is loaded.
// Configuration (csr_*): registers at byte address 4*index; the user must write
// them only while no item is in flight; the block does not enforce it. Reset returns
// all registers and controller state to defaults and empties the output register.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic signed [pidaw_pkg::DATA_W-1:0] req_reference,
   input  logic signed [pidaw_pkg::DATA_W-1:0] req_measurement,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pidaw_pkg::DATA_W-1:0] rsp_duty,
   output logic                                rsp_held,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pidaw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pidaw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pidaw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import pidaw_pkg::*;

   pidaw_cfg_type cfg;
   pidaw_cmd_type cmd;
   pidaw_sts_type sts;

   pidaw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   pidaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pidaw_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_reference   (req_reference),
      .req_measurement (req_measurement),
      .rsp_duty        (rsp_duty),
      .rsp_held        (rsp_held)
   );

endmodule

// ----- design/pidaw_csr.sv -----
// ----------------------------------------------------------------------------
// pidaw_csr
// Register file for controller gains, measurement limit and output bounds.
// ----------------------------------------------------------------------------
module pidaw_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pidaw_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [pidaw_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pidaw_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready,
   output pidaw_pkg::pidaw_cfg_type          cfg
);
   import pidaw_pkg::*;

   pidaw_cfg_type cfg_ff;
   csr_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a0           <= '0;
         cfg_ff.coef_a1           <= '0;
         cfg_ff.coef_a2           <= '0;
         cfg_ff.windup_gain       <= WINDUP_RST;
         cfg_ff.measurement_limit <= LIMIT_RST;
         cfg_ff.output_low        <= '0;
         cfg_ff.output_high       <= OUT_HIGH_RST;
      end else if (wr_en) begin
         case (index)
            REG_A0:       cfg_ff.coef_a0           <= pwdata;
            REG_A1:       cfg_ff.coef_a1           <= pwdata;
            REG_A2:       cfg_ff.coef_a2           <= pwdata;
            REG_WG:       cfg_ff.windup_gain       <= pwdata;
            REG_LIMIT:    cfg_ff.measurement_limit <= pwdata;
            REG_OUT_LOW:  cfg_ff.output_low        <= pwdata;
            REG_OUT_HIGH: cfg_ff.output_high       <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_A0:       prdata = cfg_ff.coef_a0;
         REG_A1:       prdata = cfg_ff.coef_a1;
         REG_A2:       prdata = cfg_ff.coef_a2;
         REG_WG:       prdata = cfg_ff.windup_gain;
         REG_LIMIT:    prdata = cfg_ff.measurement_limit;
         REG_OUT_LOW:  prdata = cfg_ff.output_low;
         REG_OUT_HIGH: prdata = cfg_ff.output_high;
         default:      prdata = '0;
      endcase
   end

endmodule

// ----- design/pidaw_datapath.sv -----
// ----------------------------------------------------------------------------
// pidaw_datapath
// Error history, shared multiplier, accumulator, clamp and anti-windup sum.
// ----------------------------------------------------------------------------
module pidaw_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pidaw_pkg::pidaw_cfg_type          cfg,
   input  pidaw_pkg::pidaw_cmd_type          cmd,
   output pidaw_pkg::pidaw_sts_type          sts,
   input  logic                              req_command,
   input  logic signed [pidaw_pkg::DATA_W-1:0] req_reference,
   input  logic signed [pidaw_pkg::DATA_W-1:0] req_measurement,
   output logic signed [pidaw_pkg::DATA_W-1:0] rsp_duty,
   output logic                              rsp_held
);
   import pidaw_pkg::*;

   // control state
   logic signed [DATA_W-1:0] e1_ff, e2_ff, last_ff, duty_ff, pclamp_ff;

   // working registers
   logic                     cmd_ff;
   logic signed [DATA_W-1:0] ref_ff, meas_ff, e_ff, diff_ff, clamped_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     held_ff;
   logic signed [DATA_W-1:0] rsp_duty_ff;
   logic                     rsp_held_ff;

   logic signed [DATA_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] rnd_full;
   logic signed [RND_W-1:0]  rnd;
   logic signed [ACC_W-1:0]  err_wide, diff_wide, acc_sum, fin_sum;
   logic signed [DATA_W-1:0] acc_sat, clamp_val, fin_val;
   logic                     meas_over;

   always_comb begin
      case (cmd.mul_sel)
         MUL_A0:  begin mul_a = cfg.coef_a0;     mul_b = e_ff;    end
         MUL_A1:  begin mul_a = cfg.coef_a1;     mul_b = e1_ff;   end
         MUL_A2:  begin mul_a = cfg.coef_a2;     mul_b = e2_ff;   end
         MUL_WG:  begin mul_a = cfg.windup_gain; mul_b = diff_ff; end
         default: begin mul_a = cfg.windup_gain; mul_b = diff_ff; end
      endcase
   end

   assign prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
   // round half up, then floor shift back to Q16.16
   assign rnd_full = prod_ff + ROUND_HALF;
   assign rnd      = rnd_full[PROD_W-1:FRAC_W];

   assign err_wide  = ACC_W'(ref_ff) - ACC_W'(meas_ff);
   assign diff_wide = ACC_W'(duty_ff) - ACC_W'(pclamp_ff);
   assign acc_sum   = acc_ff + ACC_W'(rnd);
   assign acc_sat   = sat_data(acc_ff);
   assign fin_sum   = ACC_W'(rnd) + ACC_W'(clamped_ff);
   assign fin_val   = sat_data(fin_sum);
   assign meas_over = meas_ff > cfg.measurement_limit;

   // with inverted bounds, values above the upper bound take it, all others take the lower bound
   always_comb begin
      if (acc_sat > cfg.output_high) begin
         clamp_val = cfg.output_high;
      end else if (acc_sat < cfg.output_low) begin
         clamp_val = cfg.output_low;
      end else begin
         clamp_val = acc_sat;
      end
   end

   assign sts.clear = cmd_ff;
   assign sts.held  = meas_over;
   assign rsp_duty  = rsp_duty_ff;
   assign rsp_held  = rsp_held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_ff     <= '0;
         e2_ff     <= '0;
         last_ff   <= '0;
         duty_ff   <= DUTY_RST;
         pclamp_ff <= DUTY_RST;
      end else if (cmd.check && cmd_ff) begin
         e1_ff   <= '0;
         e2_ff   <= '0;
         last_ff <= '0;
      end else if (cmd.finish) begin
         e2_ff     <= e1_ff;
         e1_ff     <= e_ff;
         last_ff   <= fin_val;
         duty_ff   <= fin_val;
         pclamp_ff <= clamped_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         ref_ff  <= req_reference;
         meas_ff <= req_measurement;
      end
      if (cmd.check) begin
         e_ff    <= sat_data(err_wide);
         diff_ff <= sat_data(diff_wide);
         acc_ff  <= ACC_W'(last_ff);
         held_ff <= !cmd_ff && meas_over;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_sum;
      end
      if (cmd.clamp) begin
         clamped_ff <= clamp_val;
      end
      if (cmd.load_out) begin
         rsp_duty_ff <= duty_ff;
         rsp_held_ff <= held_ff;
      end
   end

   a_finish_tracks: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> duty_ff == last_ff)
      else $error("duty and accumulator differ after a control step");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (cmd.check && cmd_ff) |=> (e1_ff == '0 && e2_ff == '0 && last_ff == '0))
      else $error("clear left history or accumulator nonzero");

endmodule

// ----- design/pidaw_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidaw_ctrl
// Sequencer: steps one item through check, four multiplies, clamp and update
// (check only for a clear or held item), then loads the output register.
// ----------------------------------------------------------------------------
module pidaw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  pidaw_pkg::pidaw_sts_type sts,
   output pidaw_pkg::pidaw_cmd_type cmd
);
   import pidaw_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_M0,
      S_M1,
      S_M2,
      S_M3,
      S_CLAMP,
      S_FIN,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, out_free;

   assign req_stall = reset || (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_WG;
      cmd.capture  = accept;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.clear || sts.held) state_in = S_DONE;
            else                       state_in = S_M0;
         end
         S_M0: begin
            cmd.mul_sel = MUL_A0;
            state_in    = S_M1;
         end
         S_M1: begin
            cmd.mul_sel = MUL_A1;
            cmd.acc_add = 1'b1;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.mul_sel = MUL_A2;
            cmd.acc_add = 1'b1;
            state_in    = S_M3;
         end
         S_M3: begin
            cmd.acc_add = 1'b1;
            state_in    = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            // wait for the output register to drain
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_CHECK)
      else $error("accepted transfer did not start a step");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the done state");

   a_short_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && (sts.clear || sts.held)) |=> state_ff == S_DONE)
      else $error("clear or held item ran the full step");

endmodule

// ----- verif/pid_antiwindup_controller_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_antiwindup_controller_core_test
// Self-checking bench for the incremental PID core with anti-windup. A short
// table of directed rows sets registers and sends items, then five random
// phases (nominal, extreme, inverted bounds, full range, no idling) stress
// the core. Each accepted result is checked against an in-bench controller
// model or a typed table value; register writes are read back over the same port.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller_core_test;
   import pidaw_pkg::*;

   localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] LIM_DEF = 32'sd8519680;

   localparam int IDLE_PCT        = 11;
   localparam int HOLD_CYCLES     = 300;
   localparam int QUIET_LIMIT     = 5000;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int NUM_PHASES      = 5;
   localparam int PHASE_NOMINAL   = 0;
   localparam int PHASE_EXTREME   = 1;
   localparam int PHASE_INVERTED  = 2;
   localparam int PHASE_WILD      = 3;
   localparam int PHASE_CALM      = 4;
   localparam int NUM_DIRECTED    = 34;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      csr_index_type            reg_idx;
      logic signed [DATA_W-1:0] cfg_value;
      logic                     command;
      logic signed [DATA_W-1:0] setpoint;
      logic signed [DATA_W-1:0] meas;
      bit                       typed;
      logic signed [DATA_W-1:0] duty;
      logic                     held;
   } stim_row_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] duty;
      logic                     held;
   } duty_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_command;
   logic signed [DATA_W-1:0] req_reference;
   logic signed [DATA_W-1:0] req_measurement;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_duty;
   logic                     rsp_held;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_W-1:0]    csr_paddr;
   logic [CSR_DATA_W-1:0]    csr_pwdata;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   pid_antiwindup_controller_core u_dut (.*);

   // controller model: register copies and loop state
   logic signed [DATA_W-1:0] k_e0, k_e1, k_e2, k_wind;
   logic signed [DATA_W-1:0] meas_limit, clamp_low, clamp_high;
   logic signed [DATA_W-1:0] err_hist1, err_hist2, acc_last, duty_now, clamp_prev;

   duty_result_type pending_duty_q [$];
   duty_result_type want;
   int              mismatches = 0;
   int              idle_pct = IDLE_PCT;
   bit              hold_request = 1'b0;

   // setpoint / measurement extremes first, then gains, saturation and bounds
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{ROW_ITEM, REG_A0, 0, 1'b1, 0, 0, 1, 32'sd6554, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 0, LIM_DEF + 1, 1, 32'sd6554, 1'b1},
      '{ROW_ITEM, REG_A0, 0, 1'b0, S32_MIN, S32_MAX, 1, 32'sd6554, 1'b1},
      '{ROW_ITEM, REG_A0, 0, 1'b0, S32_MIN, LIM_DEF, 1, 32'sd0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, S32_MAX, S32_MIN, 1, 32'sd0, 1'b0},
      '{ROW_CFG, REG_A0, 32'sh0100_0000, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_A1, 32'shfe00_0000, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_A2, 32'sh0100_0000, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_OUT_LOW, -32'sd262144, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_OUT_HIGH, 32'sd262144, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 32'sd65536, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 32'sd32768, 32'sd49152, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, -32'sd65536, 32'sd65536, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b1, 0, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 32'sd131072, -32'sd8, 0, 0, 1'b0},
      '{ROW_CFG, REG_A0, S32_MAX, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_WG, S32_MIN, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_LIMIT, S32_MAX, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_OUT_LOW, S32_MIN, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_OUT_HIGH, S32_MAX, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, S32_MAX, S32_MIN, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, S32_MIN, S32_MAX, 0, 0, 1'b0},
      '{ROW_CFG, REG_OUT_LOW, 32'sd65536, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_OUT_HIGH, -32'sd65536, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 32'sd1048576, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, -32'sd1048576, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_LIMIT, S32_MIN, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 0, S32_MIN, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 0, S32_MIN + 1, 0, 0, 1'b0},
      '{ROW_CFG, REG_OUT_LOW, 32'sd196608, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_CFG, REG_OUT_HIGH, 32'sd196608, 1'b0, 0, 0, 0, 0, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b0, 32'sd100, S32_MIN, 1, 32'sd196608, 1'b0},
      '{ROW_ITEM, REG_A0, 0, 1'b1, S32_MAX, S32_MAX, 1, 32'sd196608, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [DATA_W-1:0] sat32(input longint x);
      if (x > longint'(S32_MAX)) return S32_MAX;
      if (x < longint'(S32_MIN)) return S32_MIN;
      return x[DATA_W-1:0];
   endfunction

   // Q8.24 gain times Q16.16 signal, rounded half up back to Q16.16
   function automatic longint scale_q24(input logic signed [DATA_W-1:0] gain,
                                        input logic signed [DATA_W-1:0] sig);
      longint g;
      longint s;
      g = gain;
      s = sig;
      return (g * s + 64'sd8388608) >>> FRAC_W;
   endfunction

   function automatic void reset_controller_model();
      k_e0       = 0;
      k_e1       = 0;
      k_e2       = 0;
      k_wind     = 32'sd2399;
      meas_limit = LIM_DEF;
      clamp_low  = 0;
      clamp_high = 32'sd65536;
      err_hist1  = 0;
      err_hist2  = 0;
      acc_last   = 0;
      duty_now   = 32'sd6554;
      clamp_prev = 32'sd6554;
   endfunction

   function automatic duty_result_type compute_duty(input logic cmd,
                                                    input logic signed [DATA_W-1:0] sp,
                                                    input logic signed [DATA_W-1:0] mv);
      duty_result_type          r;
      logic signed [DATA_W-1:0] err;
      logic signed [DATA_W-1:0] clamped;
      logic signed [DATA_W-1:0] diff;
      longint                   raw;
      r.held = 1'b0;
      if (cmd) begin
         err_hist1 = 0;
         err_hist2 = 0;
         acc_last  = 0;
      end else if (mv <= meas_limit) begin
         err = sat32(longint'(sp) - longint'(mv));
         raw = scale_q24(k_e0, err) + scale_q24(k_e1, err_hist1)
             + scale_q24(k_e2, err_hist2) + longint'(acc_last);
         clamped = sat32(raw);
         err_hist2 = err_hist1;
         err_hist1 = err;
         // with inverted bounds, values above the upper bound take it, all others take the lower bound
         if (clamped > clamp_high) begin
            clamped = clamp_high;
         end else if (clamped < clamp_low) begin
            clamped = clamp_low;
         end
         diff = sat32(longint'(duty_now) - longint'(clamp_prev));
         duty_now   = sat32(scale_q24(k_wind, diff) + longint'(clamped));
         acc_last   = duty_now;
         clamp_prev = clamped;
      end else begin
         r.held = 1'b1;
      end
      r.duty = duty_now;
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_item(input logic cmd, input logic signed [DATA_W-1:0] sp,
                             input logic signed [DATA_W-1:0] mv, input bit typed,
                             input logic signed [DATA_W-1:0] typed_duty,
                             input logic typed_held);
      duty_result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_valid       <= 1'b0;
         req_command     <= 1'($urandom);
         req_reference   <= $urandom;
         req_measurement <= $urandom;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_reference   <= sp;
      req_measurement <= mv;
      do @(posedge clock); while (req_stall);
      predicted = compute_duty(cmd, sp, mv);
      if (typed) begin
         predicted.duty = typed_duty;
         predicted.held = typed_held;
      end
      pending_duty_q.push_back(predicted);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_duty_q.size() != 0) @(negedge clock);
   endtask

   // Write one register, then read it back.
   task automatic program_register(input csr_index_type idx,
                                   input logic signed [DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // hold the bus idle before the next transfer
      @(negedge clock);
      case (idx)
         REG_A0:       k_e0 = value;
         REG_A1:       k_e1 = value;
         REG_A2:       k_e2 = value;
         REG_WG:       k_wind = value;
         REG_LIMIT:    meas_limit = value;
         REG_OUT_LOW:  clamp_low = value;
         REG_OUT_HIGH: clamp_high = value;
         default: ;
      endcase
      if (rd !== value) begin
         $error("csr %s: expected %h, got %h", idx.name(), value, rd);
         mismatches++;
      end
   endtask

   function automatic logic signed [DATA_W-1:0] draw_gain(input int phase);
      case (phase)
         PHASE_EXTREME: return $urandom_range(1) ? S32_MAX : S32_MIN;
         PHASE_WILD:    return $urandom;
         default:       return int'($urandom_range(1 << 26)) - (1 << 25);
      endcase
   endfunction

   task automatic configure_phase(input int phase);
      logic signed [DATA_W-1:0] word [7];
      wait_drained();
      word[REG_A0] = draw_gain(phase);
      word[REG_A1] = draw_gain(phase);
      word[REG_A2] = draw_gain(phase);
      word[REG_WG] = draw_gain(phase);
      case (phase)
         PHASE_EXTREME: begin
            word[REG_LIMIT]    = S32_MAX;
            word[REG_OUT_LOW]  = S32_MIN;
            word[REG_OUT_HIGH] = S32_MAX;
         end
         PHASE_INVERTED: begin
            word[REG_LIMIT]    = int'($urandom_range(1 << 21)) + (1 << 19);
            word[REG_OUT_LOW]  = int'($urandom_range(1 << 20, 1));
            word[REG_OUT_HIGH] = -int'($urandom_range(1 << 20));
         end
         PHASE_WILD: begin
            word[REG_LIMIT]    = $urandom;
            word[REG_OUT_LOW]  = $urandom;
            word[REG_OUT_HIGH] = $urandom;
         end
         default: begin
            word[REG_LIMIT]    = int'($urandom_range(1 << 21)) + (1 << 19);
            word[REG_OUT_LOW]  = -int'($urandom_range(1 << 20));
            word[REG_OUT_HIGH] = int'($urandom_range(1 << 20));
         end
      endcase
      for (int i = 0; i < 7; i++) begin
         program_register(csr_index_type'(i), word[i]);
      end
   endtask

   initial begin : stimulus
      int                       roll;
      logic                     cmd;
      logic signed [DATA_W-1:0] sp;
      logic signed [DATA_W-1:0] mv;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = 1'b0;
      req_reference   = '0;
      req_measurement = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      reset_controller_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            wait_drained();
            program_register(directed_rows[i].reg_idx, directed_rows[i].cfg_value);
         end else begin
            offer_item(directed_rows[i].command, directed_rows[i].setpoint,
                       directed_rows[i].meas, directed_rows[i].typed,
                       directed_rows[i].duty, directed_rows[i].held);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         configure_phase(phase);
         idle_pct = (phase == PHASE_CALM) ? 0 : IDLE_PCT;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == PHASE_NOMINAL && n == 100) hold_request = 1'b1;
            roll = $urandom_range(99);
            cmd  = (roll < 4);
            if (roll >= 4 && roll < 80) begin
               // tracking steps: small error around a moving setpoint
               sp = int'($urandom_range(1 << 21)) - (1 << 20);
               mv = sp + int'($urandom_range(1 << 15)) - (1 << 14);
            end else if (roll >= 80 && roll < 90) begin
               sp = $urandom;
               mv = meas_limit + int'($urandom_range(2)) - 1;
            end else begin
               sp = $urandom;
               mv = $urandom;
            end
            offer_item(cmd, sp, mv, 1'b0, '0, 1'b0);
         end
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_duty_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Result side: random stall, plus one long hold-off to back up the input.
   initial begin : result_drain
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_duty_q.size() == 0) begin
            $error("result with nothing pending: duty %0d, held %0b", rsp_duty, rsp_held);
            mismatches++;
         end else begin
            want = pending_duty_q.pop_front();
            if (rsp_duty !== want.duty) begin
               $error("duty: expected %0d, got %0d", want.duty, rsp_duty);
               mismatches++;
            end
            if (rsp_held !== want.held) begin
               $error("held: expected %0b, got %0b", want.held, rsp_held);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_psel && csr_penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $error("no transfer for %0d cycles, %0d results pending", QUIET_LIMIT,
             pending_duty_q.size());
      $display("FAILURE");
      $finish;
   end

endmodule
